// ===== hdl/qrm_pkg.sv =====
`timescale 1ns / 1ps

package qrm_pkg;

  // component and result formats
  localparam int CompWidth = 16;
  localparam int FracBits  = 14;
  localparam int OutWidth  = 20;
  localparam int NumEntries = 9;

  // quotient bits: one guard bit above the result magnitude flags overflow
  localparam int QuotBits  = OutWidth + 1;
  localparam int QIdxWidth = $clog2(QuotBits);

  // internal widths
  localparam int ProdWidth = 2 * CompWidth;
  localparam int PairWidth = ProdWidth + 1;
  localparam int SumWidth  = 2 * CompWidth + 1;
  localparam int OneExp    = 2 * FracBits;
  localparam int DivWidth  = (SumWidth > OneExp + 1) ? SumWidth : OneExp + 1;
  localparam int MWidth    = DivWidth + 1;
  localparam int NWidth    = MWidth + FracBits + 2;
  localparam int BWidth    = DivWidth + 1;
  localparam int RWidth    = BWidth + QuotBits;

  // configuration
  localparam int CfgIdxWidth    = 8;
  localparam int CfgDataWidth   = 16;
  localparam int ZeroLimitWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_NORM_EN    = 8'd0,
    REG_ZERO_LIMIT = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] qx;
    logic signed [CompWidth-1:0] qy;
    logic signed [CompWidth-1:0] qz;
    logic signed [CompWidth-1:0] qw;
  } quat_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] r00;
    logic signed [OutWidth-1:0] r01;
    logic signed [OutWidth-1:0] r02;
    logic signed [OutWidth-1:0] r10;
    logic signed [OutWidth-1:0] r11;
    logic signed [OutWidth-1:0] r12;
    logic signed [OutWidth-1:0] r20;
    logic signed [OutWidth-1:0] r21;
    logic signed [OutWidth-1:0] r22;
  } rot_t;

endpackage

// ===== hdl/quaternion_to_rotation_matrix.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     in_data   (quat_t: qx qy qz qw, Q1.14)
// out_      output     out_valid / out_ready   out_data  (rot_t: r00..r22, Q5.14)
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// one transaction per cycle while out_ready does not stall the output; each result
// passes through the 21-step restoring divider, one quotient bit per stage
// each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stalled output does not block empty stages
// synchronous active-low reset clears the valid bits and the two registers
// (normalise on, zero limit one); cfg_ready is always high
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  quat_t                   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rot_t                    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_wdata
);

  localparam int DivFirst  = 5;
  localparam int NumStages = DivFirst + QuotBits + 1;
  localparam int OutStage  = NumStages - 1;
  localparam logic [DivWidth-1:0] One = DivWidth'(1) << OneExp;
  localparam logic signed [OutWidth-1:0] OutMax = {1'b0, {(OutWidth-1){1'b1}}};
  localparam logic signed [OutWidth-1:0] OutMin = {1'b1, {(OutWidth-1){1'b0}}};

  typedef struct packed {
    logic [RWidth-1:0]   rem;
    logic [QuotBits-1:0] quo;
  } step_t;

  // one restoring step: subtract the divisor shifted to bit k if it fits
  function automatic step_t div_step(input logic [RWidth-1:0] rem,
                                     input logic [QuotBits-1:0] quo,
                                     input logic [BWidth-1:0] b,
                                     input logic [QIdxWidth-1:0] k);
    step_t             r;
    logic [RWidth-1:0] sh;
    sh    = RWidth'(b) << k;
    r.rem = rem;
    r.quo = quo;
    if (rem >= sh) begin
      r.rem    = rem - sh;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  // sign and saturation of the floored quotient magnitude
  function automatic logic signed [OutWidth-1:0] sat_entry(input logic [QuotBits-1:0] q,
                                                           input logic neg);
    logic signed [OutWidth-1:0] r;
    if (!neg) begin
      if (q[QuotBits-1] || q[OutWidth-1]) r = OutMax;
      else                                r = q[OutWidth-1:0];
    end else begin
      if (q[QuotBits-1] || (q[OutWidth-1] && (|q[OutWidth-2:0]))) r = OutMin;
      else r = OutWidth'(0) - q[OutWidth-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic                      norm_en_r;
  logic [ZeroLimitWidth-1:0] zero_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_en_r    <= 1'b1;
      zero_limit_r <= ZeroLimitWidth'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NORM_EN:    norm_en_r    <= cfg_wdata[0];
        REG_ZERO_LIMIT: zero_limit_r <= cfg_wdata[ZeroLimitWidth-1:0];
        default: ;
      endcase
    end
  end

  // stage advance chain and valid bits
  logic [NumStages-1:0] vld_r;
  logic [NumStages:0]   adv;

  always_comb begin
    adv[NumStages] = out_ready;
    for (int i = NumStages - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[OutStage];

  // stage 0: input register
  logic signed [CompWidth-1:0] x_r, y_r, z_r, w_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_r <= in_data.qx;
      y_r <= in_data.qy;
      z_r <= in_data.qz;
      w_r <= in_data.qw;
    end
  end

  // stage 1: the ten products
  logic signed [ProdWidth-1:0] xx_r, yy_r, zz_r, ww_r;
  logic signed [ProdWidth-1:0] xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      ww_r <= w_r * w_r;
      xy_r <= x_r * y_r;
      xz_r <= x_r * z_r;
      yz_r <= y_r * z_r;
      xw_r <= x_r * w_r;
      yw_r <= y_r * w_r;
      zw_r <= z_r * w_r;
    end
  end

  // stage 2: sum of squares and pairwise sums
  logic [SumWidth-1:0]         s_r, syz_r, sxz_r, sxy_r;
  logic signed [PairWidth-1:0] pxy_m_r, pxy_p_r, pxz_m_r, pxz_p_r, pyz_m_r, pyz_p_r;
  logic [SumWidth-1:0]         uxx, uyy, uzz, uww;

  assign uxx = SumWidth'($unsigned(xx_r));
  assign uyy = SumWidth'($unsigned(yy_r));
  assign uzz = SumWidth'($unsigned(zz_r));
  assign uww = SumWidth'($unsigned(ww_r));

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s_r     <= (uxx + uyy) + (uzz + uww);
      syz_r   <= uyy + uzz;
      sxz_r   <= uxx + uzz;
      sxy_r   <= uxx + uyy;
      pxy_m_r <= PairWidth'(xy_r) - PairWidth'(zw_r);
      pxy_p_r <= PairWidth'(xy_r) + PairWidth'(zw_r);
      pxz_m_r <= PairWidth'(xz_r) - PairWidth'(yw_r);
      pxz_p_r <= PairWidth'(xz_r) + PairWidth'(yw_r);
      pyz_m_r <= PairWidth'(yz_r) - PairWidth'(xw_r);
      pyz_p_r <= PairWidth'(yz_r) + PairWidth'(xw_r);
    end
  end

  // stage 3: divisor choice and numerators
  logic [DivWidth-1:0]      d_r, d_nxt;
  logic signed [MWidth-1:0] m_r [NumEntries];
  logic signed [MWidth-1:0] m_nxt [NumEntries];
  logic                     s_zero, s_one;

  always_comb begin
    s_zero = (s_r == '0) || (s_r < SumWidth'(zero_limit_r));
    s_one  = (DivWidth'(s_r) == One);
    d_nxt  = (norm_en_r && !s_zero && !s_one) ? DivWidth'(s_r) : One;
    m_nxt[0] = $signed(MWidth'(d_nxt)) - $signed(MWidth'({syz_r, 1'b0}));
    m_nxt[1] = MWidth'(pxy_m_r) <<< 1;
    m_nxt[2] = MWidth'(pxz_p_r) <<< 1;
    m_nxt[3] = MWidth'(pxy_p_r) <<< 1;
    m_nxt[4] = $signed(MWidth'(d_nxt)) - $signed(MWidth'({sxz_r, 1'b0}));
    m_nxt[5] = MWidth'(pyz_m_r) <<< 1;
    m_nxt[6] = MWidth'(pxz_m_r) <<< 1;
    m_nxt[7] = MWidth'(pyz_p_r) <<< 1;
    m_nxt[8] = $signed(MWidth'(d_nxt)) - $signed(MWidth'({sxy_r, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_r <= d_nxt;
      for (int e = 0; e < NumEntries; e++) m_r[e] <= m_nxt[e];
    end
  end

  // stage 4: rounded dividend, folded to a magnitude for the floor
  logic [BWidth-1:0]        b_r;
  logic [NWidth-1:0]        n_r [NumEntries];
  logic [NumEntries-1:0]    ng_r;
  logic signed [NWidth-1:0] a_nxt [NumEntries];

  always_comb begin
    for (int e = 0; e < NumEntries; e++) begin
      a_nxt[e] = (NWidth'(m_r[e]) <<< (FracBits + 1)) + $signed(NWidth'(d_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      b_r <= {d_r, 1'b0};
      for (int e = 0; e < NumEntries; e++) begin
        ng_r[e] <= a_nxt[e][NWidth-1];
        if (a_nxt[e][NWidth-1]) n_r[e] <= (-a_nxt[e]) + NWidth'({d_r, 1'b0}) - NWidth'(1);
        else                    n_r[e] <= a_nxt[e];
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb (overflow guard) first
  logic [RWidth-1:0]     rem_r [QuotBits][NumEntries];
  logic [QuotBits-1:0]   quo_r [QuotBits][NumEntries];
  logic [NumEntries-1:0] dng_r [QuotBits];
  logic [BWidth-1:0]     db_r  [QuotBits];
  step_t                 st_nxt [QuotBits][NumEntries];

  always_comb begin
    for (int e = 0; e < NumEntries; e++) begin
      st_nxt[0][e] = div_step(RWidth'(n_r[e]), '0, b_r, QIdxWidth'(QuotBits - 1));
    end
    for (int j = 1; j < QuotBits; j++) begin
      for (int e = 0; e < NumEntries; e++) begin
        st_nxt[j][e] = div_step(rem_r[j-1][e], quo_r[j-1][e], db_r[j-1],
                                QIdxWidth'(QuotBits - 1 - j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[DivFirst]) begin
      db_r[0]  <= b_r;
      dng_r[0] <= ng_r;
      for (int e = 0; e < NumEntries; e++) begin
        rem_r[0][e] <= st_nxt[0][e].rem;
        quo_r[0][e] <= st_nxt[0][e].quo;
      end
    end
    for (int j = 1; j < QuotBits; j++) begin
      if (adv[DivFirst+j]) begin
        db_r[j]  <= db_r[j-1];
        dng_r[j] <= dng_r[j-1];
        for (int e = 0; e < NumEntries; e++) begin
          rem_r[j][e] <= st_nxt[j][e].rem;
          quo_r[j][e] <= st_nxt[j][e].quo;
        end
      end
    end
  end

  // output register: sign and saturate
  rot_t out_r;

  always_ff @(posedge clk) begin
    if (adv[OutStage]) begin
      out_r.r00 <= sat_entry(quo_r[QuotBits-1][0], dng_r[QuotBits-1][0]);
      out_r.r01 <= sat_entry(quo_r[QuotBits-1][1], dng_r[QuotBits-1][1]);
      out_r.r02 <= sat_entry(quo_r[QuotBits-1][2], dng_r[QuotBits-1][2]);
      out_r.r10 <= sat_entry(quo_r[QuotBits-1][3], dng_r[QuotBits-1][3]);
      out_r.r11 <= sat_entry(quo_r[QuotBits-1][4], dng_r[QuotBits-1][4]);
      out_r.r12 <= sat_entry(quo_r[QuotBits-1][5], dng_r[QuotBits-1][5]);
      out_r.r20 <= sat_entry(quo_r[QuotBits-1][6], dng_r[QuotBits-1][6]);
      out_r.r21 <= sat_entry(quo_r[QuotBits-1][7], dng_r[QuotBits-1][7]);
      out_r.r22 <= sat_entry(quo_r[QuotBits-1][8], dng_r[QuotBits-1][8]);
    end
  end

  assign out_data = out_r;

  // checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (b_r != '0))
    else $error("divisor reached the divider as zero");

  a_plain_div: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !norm_en_r) |-> (d_r == One))
    else $error("divisor not unity with normalisation off");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&vld_r) && !out_ready))
    else $error("input blocked while pipeline has a free stage");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[OutStage-1]))
    else $error("result appeared without a transaction in the last divider stage");

endmodule
